// ===== sv/multitone_demodulating_controller_core_macros.svh =====
// Assertion macros used by the core, which checks itself.
`ifndef MULTITONE_DEMODULATING_CONTROLLER_CORE_MACROS_SVH
`define MULTITONE_DEMODULATING_CONTROLLER_CORE_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define MDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define MDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mdc_pkg.sv =====
package mdc_pkg;

    localparam int CHANNELS        = 6;
    localparam int COEF_WORDS      = 64;
    localparam int SINE_TABLE_BITS = 10;
    localparam int CH_BITS         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CIDX_BITS       = $clog2(COEF_WORDS);
    localparam int ST_ENTRIES      = 1 << (SINE_TABLE_BITS - 2);

    localparam logic [CIDX_BITS-1:0] PRE_BASE = CIDX_BITS'(48);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic signed [15:0]   measured_sample;
        logic signed [15:0]   desired_sample;
        logic [5:0]           coef_index;
        logic [31:0]          coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               saturated;
    } out_item_t;

    // Multiplier operand selects.
    typedef enum logic [3:0] {
        MA_NONE,
        MA_PRE_B0, MA_PRE_B1, MA_PRE_A1,
        MA_ES, MA_EC,
        MA_SB0, MA_SB1, MA_SA1,
        MA_CB0, MA_CB1, MA_CA1,
        MA_RS, MA_RC, MA_GAIN, MA_OPEN
    } mop_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_PRE_RD, ST_PRE, ST_CH_RD, ST_CH, ST_PHASE, ST_OUT
    } state_t;

    typedef struct packed {
        mop_t                 mop;
        logic [CIDX_BITS-1:0] raddr;
        logic                 coef_we;
        logic                 clr_acc;
        logic                 start_pre;
        logic                 phase_we;
        logic                 out_load;
        logic [CH_BITS-1:0]   ch;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)       return 32'sh7fffffff;
        else if (v < -64'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    // Quarter-wave sine polynomial, z in Q16, result Q1.15.
    function automatic logic [15:0] quarter_sine(input logic [16:0] z);
        logic [33:0] zz;
        logic [33:0] z2;
        logic [50:0] t;
        logic [50:0] u;
        logic [50:0] w;
        zz = 34'(z) * 34'(z);
        z2 = zz >> 16;
        t  = (51'(4640) * 51'(z2)) >> 16;
        u  = ((51'(42048) - t) * 51'(z2)) >> 16;
        w  = (((51'(102944) - u) * 51'(z)) >> 16) >> 1;
        if (w > 51'd32767) return 16'd32767;
        else               return w[15:0];
    endfunction

    function automatic logic [15:0] sine_entry(input logic [SINE_TABLE_BITS-1:0] i);
        logic [16:0] f;
        f = 17'(i) << (16 - (SINE_TABLE_BITS - 2));
        return quarter_sine(f);
    endfunction

endpackage

// ===== sv/mdc_ctrl.sv =====
module mdc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_cmd,
    input  logic             feedback_on,
    output mdc_pkg::cmd_t    cmd,
    input  mdc_pkg::status_t status
);
    import mdc_pkg::*;

    state_t             state_reg, state_next;
    logic [3:0]         step_reg, step_next;
    logic [CH_BITS-1:0] ch_reg, ch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ch_reg    <= ch_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ch_next    = ch_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                ch_next   = '0;
                if (in_valid)
                    state_next = (in_cmd == CMD_LOAD) ? ST_LOAD : ST_PRE_RD;
            end
            ST_LOAD:  state_next = ST_IDLE;
            ST_PRE_RD:
            begin
                state_next = ST_PRE;
                step_next  = '0;
            end
            ST_PRE:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd3)
                begin
                    step_next  = '0;
                    state_next = feedback_on ? ST_CH_RD : ST_PHASE;
                end
            end
            ST_CH_RD: state_next = ST_CH;
            ST_CH:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd11)
                begin
                    step_next = '0;
                    if (ch_reg == CH_BITS'(CHANNELS - 1))
                    begin
                        ch_next    = '0;
                        state_next = ST_PHASE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_CH_RD;
                    end
                end
            end
            ST_PHASE:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg[0])
                begin
                    step_next = '0;
                    if (ch_reg == CH_BITS'(CHANNELS - 1))
                        state_next = ST_OUT;
                    else
                        ch_next = ch_reg + 1'b1;
                end
            end
            ST_OUT:
                if (!status.out_full)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        logic [CIDX_BITS-1:0] base;
        base      = CIDX_BITS'({ch_reg, 3'b000});
        cmd       = '0;
        cmd.mop   = MA_NONE;
        cmd.ch    = ch_reg;
        cmd.raddr = base;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Both the store write and the sample capture happen at acceptance.
                cmd.start_pre = in_valid && (in_cmd == CMD_SAMPLE);
                cmd.coef_we   = in_valid && (in_cmd == CMD_LOAD);
            end
            ST_LOAD:  cmd.mop = MA_NONE;
            ST_PRE_RD:
            begin
                cmd.raddr   = PRE_BASE;
                cmd.clr_acc = 1'b1;
            end
            ST_PRE:
            begin
                // Coefficient for the next product is fetched in the cycle before it is used.
                cmd.raddr = PRE_BASE + CIDX_BITS'(step_reg) + CIDX_BITS'(1);
                if (step_reg == 4'd2) cmd.raddr = CIDX_BITS'(1);
                unique case (step_reg)
                    4'd0:    cmd.mop = MA_PRE_B0;
                    4'd1:    cmd.mop = MA_PRE_B1;
                    4'd2:    cmd.mop = MA_PRE_A1;
                    default: cmd.mop = feedback_on ? MA_NONE : MA_OPEN;
                endcase
            end
            ST_CH_RD: cmd.raddr = base + CIDX_BITS'(2);
            ST_CH:
            begin
                unique case (step_reg)
                    4'd0:    begin cmd.mop = MA_ES;  cmd.raddr = base + CIDX_BITS'(2); end
                    4'd1:    begin cmd.mop = MA_EC;  cmd.raddr = base + CIDX_BITS'(2); end
                    4'd2:    begin cmd.mop = MA_SB0; cmd.raddr = base + CIDX_BITS'(3); end
                    4'd3:    begin cmd.mop = MA_SB1; cmd.raddr = base + CIDX_BITS'(4); end
                    4'd4:    begin cmd.mop = MA_SA1; cmd.raddr = base + CIDX_BITS'(2); end
                    4'd5:    begin cmd.mop = MA_CB0; cmd.raddr = base + CIDX_BITS'(3); end
                    4'd6:    begin cmd.mop = MA_CB1; cmd.raddr = base + CIDX_BITS'(4); end
                    4'd7:    begin cmd.mop = MA_CA1; cmd.raddr = base + CIDX_BITS'(1); end
                    4'd8:    begin cmd.mop = MA_RS;  cmd.raddr = base + CIDX_BITS'(1); end
                    4'd9:    begin cmd.mop = MA_RC;  cmd.raddr = base + CIDX_BITS'(1); end
                    4'd10:   begin cmd.mop = MA_NONE; cmd.raddr = base + CIDX_BITS'(1); end
                    default: begin cmd.mop = MA_GAIN; cmd.raddr = base; end
                endcase
            end
            ST_PHASE:
            begin
                cmd.raddr    = base;
                cmd.phase_we = step_reg[0];
            end
            ST_OUT:   cmd.out_load = !status.out_full;
            default:  cmd.mop = MA_NONE;
        endcase
    end
endmodule

// ===== sv/mdc_dp.sv =====
module mdc_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  mdc_pkg::in_item_t  in_data,
    input  mdc_pkg::cmd_t      cmd,
    output mdc_pkg::status_t   status,
    output logic               out_valid,
    input  logic               out_ready,
    output mdc_pkg::out_item_t out_data
);
    import mdc_pkg::*;

    localparam logic [15:0] SINE_PEAK = sine_entry(SINE_TABLE_BITS'(ST_ENTRIES));

    logic [31:0] coef_mem [COEF_WORDS];
    logic [31:0] coef_rd_reg;

    logic signed [15:0] meas_reg, des_reg;
    logic signed [31:0] fm_reg, pm_reg;
    logic signed [31:0] err_reg;
    logic [31:0]        phase_reg [CHANNELS];
    logic signed [31:0] pse_reg [CHANNELS];
    logic signed [31:0] pce_reg [CHANNELS];
    logic signed [31:0] sbo_reg [CHANNELS];
    logic signed [31:0] cbo_reg [CHANNELS];

    logic signed [15:0] s_reg, c_reg;
    logic signed [31:0] es_reg, ec_reg, remod_reg;
    logic signed [63:0] facc_reg;  // filter / remod sum
    logic signed [63:0] acc_reg;   // drive accumulator
    logic               valid_reg;
    out_item_t          out_reg;

    // Coefficient store, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.coef_we)
            coef_mem[in_data.coef_index] <= in_data.coef_value;
        coef_rd_reg <= coef_mem[cmd.raddr];
    end

    // Quarter-wave sine table, built from constants.
    logic [15:0] sine_lut [ST_ENTRIES];
    for (genvar g = 0; g < ST_ENTRIES; g++)
    begin : g_lut
        assign sine_lut[g] = sine_entry(SINE_TABLE_BITS'(g));
    end

    // Trig lookup for the current channel.
    logic [31:0]                phase;
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-3:0] fidx;
    logic [SINE_TABLE_BITS-3:0] fidx_neg;
    logic [15:0]                sz, sr;
    logic signed [15:0]         s_w, c_w;
    assign phase    = phase_reg[cmd.ch];
    assign quad     = phase[31:30];
    assign fidx     = phase[29 -: (SINE_TABLE_BITS - 2)];
    assign fidx_neg = '0 - fidx;
    assign sz       = sine_lut[fidx];
    // The mirrored index reaches the quarter-wave peak when the fraction is zero.
    assign sr       = (fidx == '0) ? SINE_PEAK : sine_lut[fidx_neg];
    always_comb
    begin
        case (quad)
            2'd0:    begin s_w = sz;  c_w = sr;  end
            2'd1:    begin s_w = sr;  c_w = -sz; end
            2'd2:    begin s_w = -sz; c_w = -sr; end
            default: begin s_w = -sr; c_w = sz;  end
        endcase
    end

    // Shared multiplier: 32 by 32 signed, operands chosen by the command.
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [31:0] coef_s;
    assign coef_s = coef_rd_reg;
    always_comb
    begin
        ma = coef_s;
        mb = '0;
        case (cmd.mop)
            MA_PRE_B0: mb = 32'(meas_reg) <<< 16;
            MA_PRE_B1: mb = pm_reg;
            MA_PRE_A1: mb = fm_reg;
            MA_ES:     begin ma = err_reg; mb = 32'(s_reg); end
            MA_EC:     begin ma = err_reg; mb = 32'(c_reg); end
            MA_SB0:    mb = es_reg;
            MA_SB1:    mb = pse_reg[cmd.ch];
            MA_SA1:    mb = sbo_reg[cmd.ch];
            MA_CB0:    mb = ec_reg;
            MA_CB1:    mb = pce_reg[cmd.ch];
            MA_CA1:    mb = cbo_reg[cmd.ch];
            MA_RS:     begin ma = sbo_reg[cmd.ch]; mb = 32'(s_reg); end
            MA_RC:     begin ma = cbo_reg[cmd.ch]; mb = 32'(c_reg); end
            MA_GAIN:   mb = remod_reg;
            MA_OPEN:   mb = 32'(des_reg);
            default:   mb = '0;
        endcase
    end
    assign prod = ma * mb;

    logic signed [63:0] p24;
    assign p24 = prod >>> 24;

    // New filtered measurement; the error is formed from the saturated value.
    logic signed [31:0] fm_new;
    assign fm_new = sat32(facc_reg - p24);

    logic signed [63:0] dfin;
    assign dfin = acc_reg >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_reg  <= '0;
            des_reg   <= '0;
            fm_reg    <= '0;
            pm_reg    <= '0;
            err_reg   <= '0;
            es_reg    <= '0;
            ec_reg    <= '0;
            remod_reg <= '0;
            facc_reg  <= '0;
            acc_reg   <= '0;
            s_reg     <= '0;
            c_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pse_reg[i] <= '0;
                pce_reg[i] <= '0;
                sbo_reg[i] <= '0;
                cbo_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.start_pre)
            begin
                meas_reg <= in_data.measured_sample;
                des_reg  <= in_data.desired_sample;
            end
            if (cmd.clr_acc)
            begin
                facc_reg <= '0;
                acc_reg  <= '0;
            end
            case (cmd.mop)
                MA_PRE_B0, MA_SB0, MA_CB0: facc_reg <= p24;
                MA_PRE_B1, MA_SB1, MA_CB1: facc_reg <= facc_reg + p24;
                MA_PRE_A1:
                begin
                    fm_reg  <= fm_new;
                    pm_reg  <= 32'(meas_reg) <<< 16;
                    err_reg <= sat32((64'(des_reg) <<< 16) - 64'(fm_new));
                end
                MA_ES:
                begin
                    es_reg <= sat32(prod >>> 15);
                end
                MA_EC:     ec_reg <= sat32(prod >>> 15);
                MA_SA1:
                begin
                    sbo_reg[cmd.ch] <= sat32(facc_reg - p24);
                    pse_reg[cmd.ch] <= es_reg;
                end
                MA_CA1:
                begin
                    cbo_reg[cmd.ch] <= sat32(facc_reg - p24);
                    pce_reg[cmd.ch] <= ec_reg;
                end
                MA_RS:     facc_reg <= prod;
                MA_RC:     remod_reg <= sat32((facc_reg + prod) >>> 15);
                MA_GAIN:   acc_reg <= acc_reg + p24;
                MA_OPEN:   acc_reg <= p24 <<< 16;
                default:   ;
            endcase
            // Trig values are latched in every cycle with no product selected, so ahead of each channel's products.
            if (cmd.mop == MA_NONE)
            begin
                s_reg <= s_w;
                c_reg <= c_w;
            end
        end
    end

    // Phases reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                phase_reg[i] <= '0;
        end
        else if (cmd.phase_we)
            phase_reg[cmd.ch] <= phase_reg[cmd.ch] + coef_rd_reg;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.out_load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (dfin > 64'sd32767)
                out_reg <= '{drive: 16'sh7fff, saturated: 1'b1};
            else if (dfin < -64'sd32768)
                out_reg <= '{drive: 16'sh8000, saturated: 1'b1};
            else
                out_reg <= '{drive: dfin[15:0], saturated: 1'b0};
        end
    end

    assign status.out_full = valid_reg && !out_ready;
    assign out_valid = valid_reg;
    assign out_data  = out_reg;
endmodule

// ===== sv/multitone_demodulating_controller_core.sv =====
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+----------------------------
// in        | input     | in_valid/in_ready  | in_data (in_item_t)
// out       | output    | out_valid/out_ready| out_data (out_item_t)
// config    | input     | cfg_we             | cfg_wdata (feedback_on)
//
// A load transaction passes through its load state back to idle. A sample
// transaction runs the prefilter, the per-channel steps with feedback on, the
// phase update and output; its products all use the single shared 32 by 32 multiplier.
// Reset clears control state, the filter and phase state and the output valid
// flag asynchronously.
// A result waiting on out_ready holds the controller in its output state; the
// input channel is not ready again until the result register can take it.
module multitone_demodulating_controller_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mdc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mdc_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_wdata
);
    import mdc_pkg::*;

`include "multitone_demodulating_controller_core_macros.svh"

    logic    fb_reg;
    cmd_t    cmd;
    status_t status;

    // The feedback switch is a plain register; write it while idle (not enforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fb_reg <= 1'b0;
        else if (cfg_we)
            fb_reg <= cfg_wdata;
    end

    mdc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_cmd      (in_data.cmd),
        .feedback_on (fb_reg),
        .cmd         (cmd),
        .status      (status)
    );

    mdc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // A result is only loaded when the output register is free.
    `MDC_ASSERT_SAME(a_load_free, clk, rst_n, cmd.out_load, !(out_valid && !out_ready), "output overwritten")
    // A load transaction never produces a result on the next cycle.
    `MDC_ASSERT_NEXT(a_load_quiet, clk, rst_n, in_valid && in_ready && in_data.cmd == CMD_LOAD, !cmd.out_load, "load made a result")
    // The coefficient store is written only while no sample is in flight.
    `MDC_ASSERT_SAME(a_we_idle, clk, rst_n, cmd.coef_we, !cmd.phase_we && !cmd.out_load, "store written mid-sample")
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import mdc_pkg::*;

    localparam int RAND_ITEMS = 588;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_we;
    logic cfg_wdata;

    multitone_demodulating_controller_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Predictor state: a private copy of everything the controller remembers.
    logic [31:0]        coef_mem [COEF_WORDS];
    logic [31:0]        phase_acc [CHANNELS];
    logic signed [31:0] meas_filt;
    logic signed [31:0] meas_prev;
    logic signed [31:0] sin_err_prev [CHANNELS];
    logic signed [31:0] cos_err_prev [CHANNELS];
    logic signed [31:0] sin_branch [CHANNELS];
    logic signed [31:0] cos_branch [CHANNELS];
    logic               fb_mode;

    in_item_t  pending_items [$];
    out_item_t drive_expected [$];
    int        fail_count;
    bit        quiet_tail;
    bit        hold_sink;
    int        hold_count;
    int        src_gap;
    int        sink_gap;
    int        idle_cycles;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] coef_as_signed(input int idx);
        return 64'(signed'(coef_mem[idx & (COEF_WORDS - 1)]));
    endfunction

    // First-order section over three consecutive coefficients starting at base.
    function automatic logic signed [31:0] section(input int base,
            input logic signed [31:0] x, input logic signed [31:0] xp,
            input logic signed [31:0] yp);
        logic signed [63:0] acc;
        acc = ((coef_as_signed(base) * 64'(x)) >>> 24)
            + ((coef_as_signed(base + 1) * 64'(xp)) >>> 24)
            - ((coef_as_signed(base + 2) * 64'(yp)) >>> 24);
        return clamp32(acc);
    endfunction

    function automatic logic signed [31:0] poly_sine(input logic [63:0] z);
        logic [63:0] z2;
        logic [63:0] t;
        z2 = (z * z) >> 16;
        t = (64'd4640 * z2) >> 16;
        t = 64'd42048 - t;
        t = (t * z2) >> 16;
        t = 64'd102944 - t;
        t = ((t * z) >> 16) >> 1;
        if (t > 64'd32767) t = 64'd32767;
        return 32'(t);
    endfunction

    task automatic phase_trig(input logic [31:0] phase,
            output logic signed [31:0] s, output logic signed [31:0] c);
        logic [31:0] a;
        logic [63:0] f;
        logic signed [31:0] sz;
        logic signed [31:0] sr;
        a = phase & ~((32'd1 << (32 - SINE_TABLE_BITS)) - 32'd1);
        f = 64'((a >> 14) & 32'hffff);
        sz = poly_sine(f);
        sr = poly_sine(64'd65536 - f);
        case (a[31:30])
            2'd0: begin s = sz; c = sr; end
            2'd1: begin s = sr; c = -sz; end
            2'd2: begin s = -sz; c = -sr; end
            default: begin s = -sr; c = sz; end
        endcase
    endtask

    task automatic predict_drive(input in_item_t it);
        logic signed [31:0] meas;
        logic signed [31:0] des;
        logic signed [31:0] err;
        logic signed [31:0] s;
        logic signed [31:0] c;
        logic signed [31:0] es;
        logic signed [31:0] ec;
        logic signed [31:0] remod;
        logic signed [63:0] acc;
        logic signed [63:0] d;
        out_item_t res;
        if (it.cmd == CMD_LOAD) begin
            coef_mem[it.coef_index] = it.coef_value;
            return;
        end
        meas = 32'(it.measured_sample);
        des = 32'(it.desired_sample);
        meas_filt = section(48, meas <<< 16, meas_prev <<< 16, meas_filt);
        meas_prev = meas;
        err = clamp32((64'(des) <<< 16) - 64'(meas_filt));
        if (fb_mode) begin
            acc = 0;
            for (int i = 0; i < CHANNELS; i++) begin
                phase_trig(phase_acc[i], s, c);
                es = clamp32((64'(err) * 64'(s)) >>> 15);
                ec = clamp32((64'(err) * 64'(c)) >>> 15);
                sin_branch[i] = section(i * 8 + 2, es, sin_err_prev[i], sin_branch[i]);
                cos_branch[i] = section(i * 8 + 2, ec, cos_err_prev[i], cos_branch[i]);
                sin_err_prev[i] = es;
                cos_err_prev[i] = ec;
                remod = clamp32((64'(sin_branch[i]) * 64'(s)
                    + 64'(cos_branch[i]) * 64'(c)) >>> 15);
                acc += (coef_as_signed(i * 8 + 1) * 64'(remod)) >>> 24;
            end
            d = acc >>> 16;
        end else begin
            d = (coef_as_signed(1) * 64'(des)) >>> 24;
        end
        for (int i = 0; i < CHANNELS; i++)
            phase_acc[i] += coef_mem[(i * 8) & (COEF_WORDS - 1)];
        res.saturated = 1'b0;
        if (d > 64'sd32767) begin d = 32767; res.saturated = 1'b1; end
        if (d < -64'sd32768) begin d = -32768; res.saturated = 1'b1; end
        res.drive = d[15:0];
        drive_expected.push_back(res);
    endtask

    function automatic in_item_t load_item(input int idx, input logic [31:0] val);
        in_item_t it;
        it = '0;
        it.cmd = CMD_LOAD;
        it.coef_index = 6'(idx);
        it.coef_value = val;
        it.measured_sample = 16'($urandom);
        it.desired_sample = 16'($urandom);
        return it;
    endfunction

    function automatic in_item_t sample_item(input logic [15:0] m, input logic [15:0] t);
        in_item_t it;
        it = '0;
        it.cmd = CMD_SAMPLE;
        it.measured_sample = m;
        it.desired_sample = t;
        it.coef_index = 6'($urandom);
        it.coef_value = $urandom;
        return it;
    endfunction

    // A random Q8.24 coefficient of modest size, or a full-range word when big is set.
    function automatic logic [31:0] rand_coef(input int big);
        if (big != 0) return $urandom;
        return 32'(signed'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endfunction

    // Fills every coefficient slot, so no read ever finds an unwritten word.
    task automatic queue_coef_set(input int big);
        for (int i = 0; i < COEF_WORDS; i++) begin
            if (i % 8 == 0 && i < 48) pending_items.push_back(load_item(i, $urandom));
            else if (i % 8 == 4 || i == 50)
                pending_items.push_back(load_item(i, $urandom_range(0, 32'h00c0_0000)));
            else pending_items.push_back(load_item(i, rand_coef(big)));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || drive_expected.size() != 0 || in_valid)
            @(posedge clk);
        // Load transactions produce no result, so allow the core to finish one.
        repeat (200) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        fb_mode = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // The driver presents the oldest pending transaction and retires it on acceptance.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
            src_gap <= 0;
        end else begin
            if (in_valid && in_ready) begin
                predict_drive(in_data);
                void'(pending_items.pop_front());
            end
            if (!in_valid || in_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                        src_gap <= $urandom_range(1, 3);
                        in_valid <= 1'b0;
                    end else begin
                        in_valid <= 1'b1;
                        in_data <= pending_items[0];
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // The monitor checks each accepted result and paces out_ready.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            sink_gap <= 0;
            hold_count <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (drive_expected.size() == 0) begin
                    $error("unexpected result: drive %0d", out_data.drive);
                    fail_count++;
                end else begin
                    if (out_data.drive !== drive_expected[0].drive) begin
                        $error("drive: expected %0d, got %0d",
                            drive_expected[0].drive, out_data.drive);
                        fail_count++;
                    end
                    if (out_data.saturated !== drive_expected[0].saturated) begin
                        $error("saturated: expected %0b, got %0b",
                            drive_expected[0].saturated, out_data.saturated);
                        fail_count++;
                    end
                    void'(drive_expected.pop_front());
                end
            end
            // The long hold-off is counted here and ends on its own.
            if (hold_sink && hold_count < HOLD_CYCLES) begin
                out_ready <= 1'b0;
                hold_count <= hold_count + 1;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                out_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 2);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || hold_sink)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        fail_count = 0;
        quiet_tail = 1'b0;
        hold_sink = 1'b0;
        fb_mode = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        idle_cycles = 0;
        meas_filt = 0;
        meas_prev = 0;
        for (int i = 0; i < COEF_WORDS; i++) coef_mem[i] = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            phase_acc[i] = '0;
            sin_err_prev[i] = 0;
            cos_err_prev[i] = 0;
            sin_branch[i] = 0;
            cos_branch[i] = 0;
        end
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: load full-range words, then field extremes in both modes.
        queue_coef_set(1);
        pending_items.push_back(load_item(1, 32'h7fff_ffff));
        pending_items.push_back(sample_item(16'h7fff, 16'h7fff));
        pending_items.push_back(sample_item(16'h8000, 16'h8000));
        pending_items.push_back(sample_item(16'h0000, 16'hffff));
        pending_items.push_back(load_item(1, 32'h8000_0000));
        pending_items.push_back(sample_item(16'h7fff, 16'h7fff));
        pending_items.push_back(sample_item(16'hffff, 16'h0001));
        wait_drained();
        write_mode(1'b1);
        for (int i = 0; i < 6; i++)
            pending_items.push_back(sample_item(i[0] ? 16'h8000 : 16'h7fff,
                i[1] ? 16'h7fff : 16'h8000));
        wait_drained();

        // Random phases through several coefficient sets and both modes.
        for (int ph = 0; ph < 6; ph++) begin
            write_mode(ph[0] ? 1'b0 : 1'b1);
            queue_coef_set(ph == 5 ? 1 : 0);
            for (int n = 0; n < RAND_ITEMS / 6; n++) begin
                if ($urandom_range(0, 9) == 0)
                    pending_items.push_back(load_item($urandom_range(0, 63), rand_coef(0)));
                else
                    pending_items.push_back(sample_item(16'($urandom), 16'($urandom)));
                if (ph == 2 && n == 40) begin
                    // Back-pressure: hold results while the source keeps offering.
                    while (pending_items.size() > 0 && !in_valid) @(posedge clk);
                    hold_sink = 1'b1;
                    wait (hold_count >= HOLD_CYCLES);
                    hold_sink = 1'b0;
                end
                if (ph == 3 && n == 50) begin
                    // Source pauses until all results are back.
                    while (pending_items.size() != 0 || drive_expected.size() != 0)
                        @(posedge clk);
                end
            end
            if (ph == 5) quiet_tail = 1'b1;
            wait_drained();
        end

        if (fail_count == 0 && drive_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
